### rtl/atw_pkg.sv
package atw_pkg;

  // Coordinate and fixed-point sizing
  localparam int COORD_BITS    = 16;
  localparam int FRAC_BITS     = 16;
  localparam int FIELD_BITS    = 16;
  localparam int ACC_BITS      = 48;
  localparam int MAT_BITS      = 32;
  localparam int PROD_BITS     = MAT_BITS + COORD_BITS + 1;
  localparam int TEXEL_BITS    = ACC_BITS - FRAC_BITS;

  // Configuration port
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 64;
  localparam int SIZE_BITS     = 32;
  localparam int SETTLE        = 2;
  localparam int SETTLE_BITS   = $clog2(SETTLE + 1);

  // Request queue between front and back
  localparam int QDEPTH        = 2;
  localparam int QPTR_BITS     = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_BITS     = $clog2(QDEPTH + 1);

  localparam logic [CFG_IDX_BITS-1:0] REG_INV_XX      = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_INV_XY      = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_INV_X0      = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_INV_YX      = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_INV_YY      = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_INV_Y0      = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_SOURCE_SIZE = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_DEST_WINDOW = 3'd7;

  localparam logic [MAT_BITS-1:0] MAT_ONE = MAT_BITS'(1 << FRAC_BITS);

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [ACC_BITS-1:0]   acc_t;
  typedef logic [MAT_BITS-1:0]   mat_t;

  // Request class decided by the front
  typedef enum logic [1:0] {
    KIND_START,
    KIND_EMPTY,
    KIND_STEP
  } kind_t;

  // Settled configuration seen by front and back
  typedef struct packed {
    mat_t   inv_xx;
    mat_t   inv_xy;
    mat_t   inv_yx;
    mat_t   inv_yy;
    acc_t   start_x;
    acc_t   start_y;
    coord_t win_x0;
    coord_t win_y0;
    coord_t win_x1;
    coord_t win_y1;
    coord_t src_w;
    coord_t src_h;
  } atw_cfg_t;

  function automatic acc_t sext_mat(input mat_t v);
    return {{(ACC_BITS - MAT_BITS){v[MAT_BITS-1]}}, v};
  endfunction

  // Signed product to accumulator width, sign extended or wrapped
  function automatic acc_t fit_prod(input logic [PROD_BITS-1:0] p);
    acc_t r;
    r = {ACC_BITS{p[PROD_BITS-1]}};
    for (int i = 0; i < PROD_BITS && i < ACC_BITS; i++) begin
      r[i] = p[i];
    end
    return r;
  endfunction

endpackage

### rtl/atw_req_if.sv
interface atw_req_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

### rtl/atw_res_if.sv
interface atw_res_if import atw_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [FIELD_BITS-1:0] dest_x;
  logic [FIELD_BITS-1:0] dest_y;
  logic [FIELD_BITS-1:0] src_x;
  logic [FIELD_BITS-1:0] src_y;
  logic                  inside_res;
  logic                  last;

  modport source (output valid, output dest_x, output dest_y, output src_x,
                  output src_y, output inside_res, output last, input ready);
  modport sink   (input valid, input dest_x, input dest_y, input src_x,
                  input src_y, input inside_res, input last, output ready);
endinterface

### rtl/atw_cfg_if.sv
interface atw_cfg_if import atw_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/affine_texture_address_walker.sv
// Affine texture address walker, nearest texel.
// A request goes through the queue, the stage A step and the texel stage into the result register.
// Throughput: one request per cycle, including restarts and row wraps, while the result side is ready.
// After each config write, and after reset, requests are held off
// while the window start point goes through its multiply and add registers.
// Reset (rst, synchronous): identity matrix, zero size and window, no walk in progress.
module affine_texture_address_walker import atw_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  atw_req_if.sink   walk_req,
  atw_res_if.source walk_res,
  atw_cfg_if.sink   cfg
);

  // Settled register view, shared by front and back
  atw_cfg_t cfg_q;
  logic     settled;

  // Front to queue
  logic     push_valid;
  logic     push_ready;
  kind_t    push_kind;

  // Queue to back
  logic     pop_valid;
  logic     pop_ready;
  kind_t    pop_kind;

  // Register file; also precomputes the source point of the window start
  // so that a restart costs no more than a step.
  atw_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .cfg_q   (cfg_q),
    .settled (settled)
  );

  // Front: takes requests and sorts them into start, empty-window and step.
  atw_front u_front (
    .req        (walk_req),
    .cfg_q      (cfg_q),
    .settled    (settled),
    .push_valid (push_valid),
    .push_kind  (push_kind),
    .push_ready (push_ready)
  );

  // Two-entry queue: the front keeps taking requests while the back
  // is stalled by the result side.
  atw_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_kind  (push_kind),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_kind   (pop_kind),
    .pop_ready  (pop_ready)
  );

  // Back: raster walker with incremental adds, then the texel bounds stage
  // feeding the result register.
  atw_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_kind  (pop_kind),
    .pop_ready (pop_ready),
    .cfg_q     (cfg_q),
    .res       (walk_res)
  );

endmodule

### rtl/atw_cfg.sv
module atw_cfg import atw_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  atw_cfg_if.sink   cfg,
  output atw_cfg_t  cfg_q,
  output logic      settled
);

  mat_t                     inv_xx;
  mat_t                     inv_xy;
  mat_t                     inv_x0;
  mat_t                     inv_yx;
  mat_t                     inv_yy;
  mat_t                     inv_y0;
  logic [SIZE_BITS-1:0]     source_size;
  logic [CFG_DATA_BITS-1:0] dest_window;
  logic [SETTLE_BITS-1:0]   settle_cnt;

  logic signed [PROD_BITS-1:0] prod_xx;
  logic signed [PROD_BITS-1:0] prod_xy;
  logic signed [PROD_BITS-1:0] prod_yx;
  logic signed [PROD_BITS-1:0] prod_yy;
  acc_t                        start_x;
  acc_t                        start_y;

  coord_t win_x0;
  coord_t win_y0;
  coord_t win_x1;
  coord_t win_y1;

  assign cfg.ready = 1'b1;
  assign settled   = (settle_cnt == '0);

  assign win_x0 = dest_window[0*FIELD_BITS +: COORD_BITS];
  assign win_y0 = dest_window[1*FIELD_BITS +: COORD_BITS];
  assign win_x1 = dest_window[2*FIELD_BITS +: COORD_BITS];
  assign win_y1 = dest_window[3*FIELD_BITS +: COORD_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_xx      <= MAT_ONE;
      inv_xy      <= '0;
      inv_x0      <= '0;
      inv_yx      <= '0;
      inv_yy      <= MAT_ONE;
      inv_y0      <= '0;
      source_size <= '0;
      dest_window <= '0;
      settle_cnt  <= SETTLE_BITS'(SETTLE);
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_INV_XX:      inv_xx      <= cfg.data[MAT_BITS-1:0];
        REG_INV_XY:      inv_xy      <= cfg.data[MAT_BITS-1:0];
        REG_INV_X0:      inv_x0      <= cfg.data[MAT_BITS-1:0];
        REG_INV_YX:      inv_yx      <= cfg.data[MAT_BITS-1:0];
        REG_INV_YY:      inv_yy      <= cfg.data[MAT_BITS-1:0];
        REG_INV_Y0:      inv_y0      <= cfg.data[MAT_BITS-1:0];
        REG_SOURCE_SIZE: source_size <= cfg.data[SIZE_BITS-1:0];
        REG_DEST_WINDOW: dest_window <= cfg.data;
        default: begin
        end
      endcase
      settle_cnt <= SETTLE_BITS'(SETTLE);
    end else if (settle_cnt != '0) begin
      settle_cnt <= settle_cnt - 1'b1;
    end
  end

  // Window start point: products, then sums
  always_ff @(posedge clk) begin
    prod_xx <= $signed(inv_xx) * $signed({1'b0, win_x0});
    prod_xy <= $signed(inv_xy) * $signed({1'b0, win_y0});
    prod_yx <= $signed(inv_yx) * $signed({1'b0, win_x0});
    prod_yy <= $signed(inv_yy) * $signed({1'b0, win_y0});
  end

  always_ff @(posedge clk) begin
    start_x <= fit_prod(prod_xx) + fit_prod(prod_xy) + sext_mat(inv_x0);
    start_y <= fit_prod(prod_yx) + fit_prod(prod_yy) + sext_mat(inv_y0);
  end

  always_comb begin
    cfg_q.inv_xx  = inv_xx;
    cfg_q.inv_xy  = inv_xy;
    cfg_q.inv_yx  = inv_yx;
    cfg_q.inv_yy  = inv_yy;
    cfg_q.start_x = start_x;
    cfg_q.start_y = start_y;
    cfg_q.win_x0  = win_x0;
    cfg_q.win_y0  = win_y0;
    cfg_q.win_x1  = win_x1;
    cfg_q.win_y1  = win_y1;
    cfg_q.src_w   = source_size[0*FIELD_BITS +: COORD_BITS];
    cfg_q.src_h   = source_size[1*FIELD_BITS +: COORD_BITS];
  end

endmodule

### rtl/atw_front.sv
module atw_front import atw_pkg::*; (
  atw_req_if.sink   req,
  input  atw_cfg_t  cfg_q,
  input  logic      settled,
  output logic      push_valid,
  output kind_t     push_kind,
  input  logic      push_ready
);

  logic win_empty;

  assign win_empty = (cfg_q.win_x0 >= cfg_q.win_x1) || (cfg_q.win_y0 >= cfg_q.win_y1);

  // Hold off while the start point is being recomputed
  assign req.ready  = settled && push_ready;
  assign push_valid = req.valid && settled;

  always_comb begin
    if (req.restart) begin
      push_kind = win_empty ? KIND_EMPTY : KIND_START;
    end else begin
      push_kind = KIND_STEP;
    end
  end

endmodule

### rtl/atw_queue.sv
module atw_queue import atw_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push_valid,
  input  kind_t push_kind,
  output logic  push_ready,
  output logic  pop_valid,
  output kind_t pop_kind,
  input  logic  pop_ready
);

  kind_t                slot [QDEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QCNT_BITS-1:0] count;
  logic                 push;
  logic                 pop;

  assign push_ready = (count < QCNT_BITS'(QDEPTH));
  assign pop_valid  = (count != '0);
  assign pop_kind   = slot[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_kind;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_BITS'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_BITS'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_BITS'(QDEPTH))
    else $error("request queue overfilled");

endmodule

### rtl/atw_back.sv
module atw_back import atw_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      pop_valid,
  input  kind_t     pop_kind,
  output logic      pop_ready,
  input  atw_cfg_t  cfg_q,
  atw_res_if.source res
);

  // Walker state
  coord_t walk_x;
  coord_t walk_y;
  acc_t   row_src_x;
  acc_t   row_src_y;
  acc_t   cur_src_x;
  acc_t   cur_src_y;
  logic   walk_done;

  coord_t walk_x_next;
  coord_t walk_y_next;
  acc_t   row_src_x_next;
  acc_t   row_src_y_next;
  acc_t   cur_src_x_next;
  acc_t   cur_src_y_next;
  logic   walk_done_next;
  logic   blank_next;
  logic   last_next;
  logic   row_wrap;

  // Stage A: stepped pixel
  logic   a_valid;
  logic   a_blank;
  logic   a_last;
  coord_t a_x;
  coord_t a_y;
  acc_t   a_cx;
  acc_t   a_cy;

  logic   a_ready;
  logic   b_ready;
  logic   pop;

  logic [TEXEL_BITS-1:0] tex_x;
  logic [TEXEL_BITS-1:0] tex_y;
  logic                  hit;

  assign b_ready   = !res.valid || res.ready;
  assign a_ready   = !a_valid || b_ready;
  assign pop_ready = a_ready;
  assign pop       = pop_valid && a_ready;

  assign row_wrap = ({1'b0, walk_x} + 1'b1) >= {1'b0, cfg_q.win_x1};

  always_comb begin
    walk_x_next    = walk_x;
    walk_y_next    = walk_y;
    row_src_x_next = row_src_x;
    row_src_y_next = row_src_y;
    cur_src_x_next = cur_src_x;
    cur_src_y_next = cur_src_y;
    blank_next     = 1'b0;
    case (pop_kind)
      KIND_START: begin
        walk_x_next    = cfg_q.win_x0;
        walk_y_next    = cfg_q.win_y0;
        row_src_x_next = cfg_q.start_x;
        row_src_y_next = cfg_q.start_y;
        cur_src_x_next = cfg_q.start_x;
        cur_src_y_next = cfg_q.start_y;
      end
      KIND_EMPTY: begin
        blank_next = 1'b1;
      end
      KIND_STEP: begin
        if (walk_done) begin
          blank_next = 1'b1;
        end else if (!row_wrap) begin
          walk_x_next    = walk_x + 1'b1;
          cur_src_x_next = cur_src_x + sext_mat(cfg_q.inv_xx);
          cur_src_y_next = cur_src_y + sext_mat(cfg_q.inv_yx);
        end else begin
          walk_x_next    = cfg_q.win_x0;
          walk_y_next    = walk_y + 1'b1;
          row_src_x_next = row_src_x + sext_mat(cfg_q.inv_xy);
          row_src_y_next = row_src_y + sext_mat(cfg_q.inv_yy);
          cur_src_x_next = row_src_x_next;
          cur_src_y_next = row_src_y_next;
        end
      end
      default: begin
        blank_next = 1'b1;
      end
    endcase
    last_next = blank_next ||
                ((({1'b0, walk_x_next} + 1'b1) >= {1'b0, cfg_q.win_x1}) &&
                 (({1'b0, walk_y_next} + 1'b1) >= {1'b0, cfg_q.win_y1}));
    walk_done_next = last_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      walk_x    <= '0;
      walk_y    <= '0;
      row_src_x <= '0;
      row_src_y <= '0;
      cur_src_x <= '0;
      cur_src_y <= '0;
      walk_done <= 1'b1;
    end else if (pop) begin
      walk_x    <= walk_x_next;
      walk_y    <= walk_y_next;
      row_src_x <= row_src_x_next;
      row_src_y <= row_src_y_next;
      cur_src_x <= cur_src_x_next;
      cur_src_y <= cur_src_y_next;
      walk_done <= walk_done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      a_blank <= blank_next;
      a_last  <= last_next;
      a_x     <= walk_x_next;
      a_y     <= walk_y_next;
      a_cx    <= cur_src_x_next;
      a_cy    <= cur_src_y_next;
    end
  end

  // Stage B: texel address and bounds
  assign tex_x = a_cx[ACC_BITS-1:FRAC_BITS];
  assign tex_y = a_cy[ACC_BITS-1:FRAC_BITS];
  assign hit   = !a_blank &&
                 !a_cx[ACC_BITS-1] && (tex_x < TEXEL_BITS'(cfg_q.src_w)) &&
                 !a_cy[ACC_BITS-1] && (tex_y < TEXEL_BITS'(cfg_q.src_h));

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (b_ready) begin
      res.valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_valid && b_ready) begin
      res.dest_x     <= a_blank ? '0 : FIELD_BITS'(a_x);
      res.dest_y     <= a_blank ? '0 : FIELD_BITS'(a_y);
      res.src_x      <= hit ? FIELD_BITS'(tex_x[COORD_BITS-1:0]) : '0;
      res.src_y      <= hit ? FIELD_BITS'(tex_y[COORD_BITS-1:0]) : '0;
      res.inside_res <= hit;
      res.last       <= a_last;
    end
  end

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    a_valid && !b_ready |=> a_valid && $stable(a_cx) && $stable(a_last))
    else $error("stage A lost or changed a stalled pixel");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.inside_res |-> (res.src_x == '0) && (res.src_y == '0))
    else $error("texel address not cleared on a miss");

  a_empty_done: assert property (@(posedge clk) disable iff (rst)
    pop && (pop_kind == KIND_EMPTY) |=> walk_done)
    else $error("empty window left a walk open");

endmodule
